[src/skt_pkg.sv]
// Shared types, constants and field widths for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int KEY_W         = 16;
    localparam int PAY_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int COUNT_OUT_W   = 8;
    localparam int DEFAULT_DEPTH = 128;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_MISS     = 3'd3,
        ST_HIT      = 3'd4,
        ST_BETWEEN  = 3'd5,
        ST_OUTSIDE  = 3'd6
    } status_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_RUN
    } ctl_state_t;

    // Operation token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] pay;
        logic                    done;
        logic                    carry_valid;
        logic signed [KEY_W-1:0] carry_key;
        logic        [PAY_W-1:0] carry_pay;
        logic                    have_prev;
        logic signed [KEY_W-1:0] prev_key;
        logic        [PAY_W-1:0] prev_pay;
        status_t                 status;
        logic signed [KEY_W-1:0] entry_key;
        logic        [PAY_W-1:0] entry_pay;
        logic signed [KEY_W-1:0] below_key;
        logic        [PAY_W-1:0] below_pay;
        logic signed [KEY_W-1:0] above_key;
        logic        [PAY_W-1:0] above_pay;
    } tok_t;

    typedef struct packed {
        status_t                    status;
        logic signed [KEY_W-1:0]    entry_key;
        logic        [PAY_W-1:0]    entry_payload;
        logic signed [KEY_W-1:0]    below_key;
        logic        [PAY_W-1:0]    below_payload;
        logic signed [KEY_W-1:0]    above_key;
        logic        [PAY_W-1:0]    above_payload;
        logic [COUNT_OUT_W-1:0]     entry_count;
    } rsp_t;

endpackage

`default_nettype wire

[src/skt_if.sv]
// Command and response channel interfaces of the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

interface skt_cmd_if import skt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    op_t                     operation;
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;

    modport source (output valid, output operation, output key, output payload, input ready);
    modport sink (input valid, input operation, input key, input payload, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic signed [KEY_W-1:0] entry_key;
    logic        [PAY_W-1:0] entry_payload;
    logic signed [KEY_W-1:0] below_key;
    logic        [PAY_W-1:0] below_payload;
    logic signed [KEY_W-1:0] above_key;
    logic        [PAY_W-1:0] above_payload;
    logic [COUNT_OUT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_key, output entry_payload,
                    output below_key, output below_payload, output above_key,
                    output above_payload, output entry_count, input ready);
    modport sink (input valid, input status, input entry_key, input entry_payload,
                  input below_key, input below_payload, input above_key,
                  input above_payload, input entry_count, output ready);
endinterface

`default_nettype wire

[src/skt_cell.sv]
// One table cell: holds one entry and acts on the operation token as it passes.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell
    import skt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [CNT_W-1:0]        count,
    input  wire tok_t                    tok_in,
    input  wire logic signed [KEY_W-1:0] nbr_key,
    input  wire logic        [PAY_W-1:0] nbr_pay,
    output tok_t                         tok_out,
    output logic signed [KEY_W-1:0]      key,
    output logic        [PAY_W-1:0]      pay
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic        [PAY_W-1:0] pay_reg;
    logic        [PAY_W-1:0] pay_next;
    tok_t                    tok_reg;
    tok_t                    tok_next;
    logic                    occ;

    assign occ = (count > CNT_W'(INDEX));

    always_comb
    begin
        tok_next = tok_in;
        key_next = key_reg;
        pay_next = pay_reg;
        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                OP_INSERT:
                begin
                    if (!tok_in.done)
                    begin
                        if (!(occ && ($signed(key_reg) <= $signed(tok_in.key))))
                        begin
                            key_next             = tok_in.key;
                            pay_next             = tok_in.pay;
                            tok_next.done        = 1'b1;
                            tok_next.carry_valid = occ;
                            tok_next.carry_key   = key_reg;
                            tok_next.carry_pay   = pay_reg;
                        end
                    end
                    else if (tok_in.carry_valid)
                    begin
                        key_next             = tok_in.carry_key;
                        pay_next             = tok_in.carry_pay;
                        tok_next.carry_valid = occ;
                        tok_next.carry_key   = key_reg;
                        tok_next.carry_pay   = pay_reg;
                    end
                end
                OP_DELETE:
                begin
                    if (!tok_in.done)
                    begin
                        if (occ && (key_reg == tok_in.key))
                        begin
                            tok_next.done      = 1'b1;
                            tok_next.status    = ST_DELETED;
                            tok_next.entry_key = key_reg;
                            tok_next.entry_pay = pay_reg;
                            key_next           = nbr_key;
                            pay_next           = nbr_pay;
                        end
                    end
                    else
                    begin
                        key_next = nbr_key;
                        pay_next = nbr_pay;
                    end
                end
                OP_SEARCH:
                begin
                    if (!tok_in.done)
                    begin
                        if (!occ)
                        begin
                            tok_next.done = 1'b1;
                        end
                        else if ($signed(key_reg) < $signed(tok_in.key))
                        begin
                            tok_next.have_prev = 1'b1;
                            tok_next.prev_key  = key_reg;
                            tok_next.prev_pay  = pay_reg;
                        end
                        else
                        begin
                            tok_next.done = 1'b1;
                            if (key_reg == tok_in.key)
                            begin
                                tok_next.status    = ST_HIT;
                                tok_next.entry_key = key_reg;
                                tok_next.entry_pay = pay_reg;
                            end
                            else if (tok_in.have_prev)
                            begin
                                tok_next.status    = ST_BETWEEN;
                                tok_next.below_key = tok_in.prev_key;
                                tok_next.below_pay = tok_in.prev_pay;
                                tok_next.above_key = key_reg;
                                tok_next.above_pay = pay_reg;
                            end
                        end
                    end
                end
                OP_NOP:
                begin
                    tok_next.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            key_reg <= key_next;
            pay_reg <= pay_next;
        end
    end

    assign tok_out = tok_reg;
    assign key     = key_reg;
    assign pay     = pay_reg;

endmodule

`default_nettype wire

[src/sorted_key_table.sv]
// Sorted key table: entries of a signed key and a payload handle, kept in ascending key order.
// Commands arrive on cmd (insert, delete, search; operation code three is taken and dropped).
// Each command but code three yields one item on rsp with a status, the entry and neighbor
// fields and the number of entries stored after the command.
// The table is a chain of TABLE_DEPTH cells. A command travels down the chain as a token,
// one cell per clock, and each cell inserts, deletes with a shift from its right neighbor,
// or records search results as the token passes.
// An insert into a full table does not enter the chain; its response goes straight to the
// skid stage. One command is in the chain at a time, so a new command is taken only after
// the previous token has left the chain.
// The response sits in an output register with a one-entry skid stage ahead of it, so a
// new command is accepted while an earlier response waits for rsp.ready; while the skid
// stage holds a response cmd.ready stays low.
// Reset empties the table at once (fill count to zero); no clearing pass is needed, since
// only cells below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    skt_cmd_if.sink   cmd,
    skt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    ctl_state_t              state_reg;
    ctl_state_t              state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    pend_valid_reg;
    logic                    pend_valid_next;
    rsp_t                    pend_reg;
    rsp_t                    pend_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    rsp_t                    out_reg;

    tok_t                    tok_chain [TABLE_DEPTH+1];
    logic signed [KEY_W-1:0] cell_key [TABLE_DEPTH];
    logic        [PAY_W-1:0] cell_pay [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  chain_valid;

    tok_t                    tok_head;
    tok_t                    tok_last;
    logic                    accept;
    logic                    is_full;
    logic                    out_load;
    logic [CNT_W-1:0]        exit_count;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
    logic [CNT_W+COUNT_OUT_W-1:0] exit_wide;

    assign cmd.ready = (state_reg == CTL_IDLE) && !pend_valid_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign tok_last  = tok_chain[TABLE_DEPTH];
    assign out_load  = pend_valid_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        tok_head       = '0;
        tok_head.op    = cmd.operation;
        tok_head.key   = cmd.key;
        tok_head.pay   = cmd.payload;
        tok_head.valid = accept && (cmd.operation != OP_NOP)
                         && !((cmd.operation == OP_INSERT) && is_full);
        unique case (cmd.operation)
            OP_INSERT:
            begin
                tok_head.status    = ST_INSERTED;
                tok_head.entry_key = cmd.key;
                tok_head.entry_pay = cmd.payload;
            end
            OP_DELETE: tok_head.status = ST_MISS;
            OP_SEARCH: tok_head.status = ST_OUTSIDE;
            OP_NOP:    tok_head.status = ST_OUTSIDE;
        endcase
    end

    assign tok_chain[0] = tok_head;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] nbr_key;
        logic        [PAY_W-1:0] nbr_pay;

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign nbr_key = cell_key[i];
            assign nbr_pay = cell_pay[i];
        end
        else
        begin : g_mid
            assign nbr_key = cell_key[i+1];
            assign nbr_pay = cell_pay[i+1];
        end

        skt_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .tok_in  (tok_chain[i]),
            .nbr_key (nbr_key),
            .nbr_pay (nbr_pay),
            .tok_out (tok_chain[i+1]),
            .key     (cell_key[i]),
            .pay     (cell_pay[i])
        );

        assign chain_valid[i] = tok_chain[i+1].valid;
    end

    always_comb
    begin
        exit_count = count_reg;
        if ((tok_last.op == OP_INSERT) && (tok_last.status == ST_INSERTED))
        begin
            exit_count = count_reg + CNT_W'(1);
        end
        else if ((tok_last.op == OP_DELETE) && (tok_last.status == ST_DELETED))
        begin
            exit_count = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign exit_wide  = {{COUNT_OUT_W{1'b0}}, exit_count};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;

        unique case (state_reg)
            CTL_IDLE:
            begin
                if (tok_head.valid)
                begin
                    state_next = CTL_RUN;
                end
                else if (accept && (cmd.operation == OP_INSERT))
                begin
                    pend_next             = '0;
                    pend_next.status      = ST_FULL;
                    pend_next.entry_count = count_wide[COUNT_OUT_W-1:0];
                    pend_valid_next       = 1'b1;
                end
            end
            CTL_RUN:
            begin
                if (tok_last.valid)
                begin
                    state_next              = CTL_IDLE;
                    count_next              = exit_count;
                    pend_next.status        = tok_last.status;
                    pend_next.entry_key     = tok_last.entry_key;
                    pend_next.entry_payload = tok_last.entry_pay;
                    pend_next.below_key     = tok_last.below_key;
                    pend_next.below_payload = tok_last.below_pay;
                    pend_next.above_key     = tok_last.above_key;
                    pend_next.above_payload = tok_last.above_pay;
                    pend_next.entry_count   = exit_wide[COUNT_OUT_W-1:0];
                    pend_valid_next         = 1'b1;
                end
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (!(pend_valid_next && !pend_valid_reg))
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CTL_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.entry_key     = out_reg.entry_key;
    assign rsp.entry_payload = out_reg.entry_payload;
    assign rsp.below_key     = out_reg.below_key;
    assign rsp.below_payload = out_reg.below_payload;
    assign rsp.above_key     = out_reg.above_key;
    assign rsp.above_payload = out_reg.above_payload;
    assign rsp.entry_count   = out_reg.entry_count;

    // At most one token is ever in the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one token in the cell chain");

    // A token leaves the chain only while a command is running.
    a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.valid |-> (state_reg == CTL_RUN))
        else $error("token left the chain while idle");

    // The skid stage is always free when a token leaves the chain.
    a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.valid |-> !pend_valid_reg)
        else $error("response overwrote a pending response");

    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // An insert into a full table does not start a chain walk.
    a_full_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.operation == OP_INSERT) && is_full) |=> (state_reg == CTL_IDLE))
        else $error("insert into a full table entered the chain");

endmodule

`default_nettype wire

[bench/tb_sorted_key_table.sv]
// Self-checking testbench for the sorted key table with its own table model and random stalls.
`timescale 1ns / 1ps

module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int DEPTH = 128;

    logic clk;
    logic rst_n;

    skt_cmd_if cmd_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    logic signed [KEY_W-1:0] tbl_keys [0:DEPTH-1];
    logic        [PAY_W-1:0] tbl_pays [0:DEPTH-1];
    int                      tbl_count;

    rsp_t pending_responses [$];
    int   error_count;
    bit   no_idle;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Applies one operation to the bench copy of the table and forms the response it yields.
    function automatic bit apply_table_op(input op_t op, input logic signed [KEY_W-1:0] k,
                                          input logic [PAY_W-1:0] p, output rsp_t r);
        int pos;
        int i;
        r = '0;
        if (op == OP_NOP)
        begin
            return 1'b0;
        end
        pos = 0;
        case (op)
            OP_INSERT:
            begin
                if (tbl_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    while (pos < tbl_count && tbl_keys[pos] <= k)
                        pos++;
                    for (i = tbl_count; i > pos; i--)
                    begin
                        tbl_keys[i] = tbl_keys[i-1];
                        tbl_pays[i] = tbl_pays[i-1];
                    end
                    tbl_keys[pos] = k;
                    tbl_pays[pos] = p;
                    tbl_count++;
                    r.status        = ST_INSERTED;
                    r.entry_key     = k;
                    r.entry_payload = p;
                end
            end
            OP_DELETE:
            begin
                while (pos < tbl_count && tbl_keys[pos] != k)
                    pos++;
                if (pos >= tbl_count)
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    r.status        = ST_DELETED;
                    r.entry_key     = tbl_keys[pos];
                    r.entry_payload = tbl_pays[pos];
                    for (i = pos; i + 1 < tbl_count; i++)
                    begin
                        tbl_keys[i] = tbl_keys[i+1];
                        tbl_pays[i] = tbl_pays[i+1];
                    end
                    tbl_count--;
                end
            end
            default:
            begin
                while (pos < tbl_count && tbl_keys[pos] < k)
                    pos++;
                if (pos < tbl_count && tbl_keys[pos] == k)
                begin
                    r.status        = ST_HIT;
                    r.entry_key     = tbl_keys[pos];
                    r.entry_payload = tbl_pays[pos];
                end
                else if (pos > 0 && pos < tbl_count)
                begin
                    r.status        = ST_BETWEEN;
                    r.below_key     = tbl_keys[pos-1];
                    r.below_payload = tbl_pays[pos-1];
                    r.above_key     = tbl_keys[pos];
                    r.above_payload = tbl_pays[pos];
                end
                else
                begin
                    r.status = ST_OUTSIDE;
                end
            end
        endcase
        r.entry_count = 8'(tbl_count);
        return 1'b1;
    endfunction

    // Draws a key that is often stored already, next to a stored one, or in a narrow window.
    function automatic logic signed [KEY_W-1:0] pick_key(input logic signed [KEY_W-1:0] base);
        int r;
        logic signed [KEY_W-1:0] k;
        r = $urandom_range(99);
        if (r < 45 && tbl_count > 0)
            k = tbl_keys[$urandom_range(tbl_count - 1)];
        else if (r < 65 && tbl_count > 0)
            k = tbl_keys[$urandom_range(tbl_count - 1)] + ($urandom_range(1) ? 16'sd1 : -16'sd1);
        else if (r < 85)
            k = base + KEY_W'($urandom_range(15));
        else if (r < 90)
            k = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else
            k = KEY_W'($urandom);
        return k;
    endfunction

    task automatic send_command(input op_t op, input logic signed [KEY_W-1:0] k,
                                input logic [PAY_W-1:0] p);
        rsp_t r;
        while (!no_idle && $urandom_range(99) < 24)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.key       <= k;
        cmd_ch.payload   <= p;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (apply_table_op(op, k, p, r))
            pending_responses.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_response();
        rsp_t want;
        if (pending_responses.size() == 0)
        begin
            $display("%0t: response item with no command outstanding, expected none, got status %0d",
                     $time, int'(rsp_ch.status));
            error_count++;
        end
        else
        begin
            want = pending_responses.pop_front();
            check_field("status", int'(want.status), int'(rsp_ch.status));
            check_field("entry_key", int'($signed(want.entry_key)),
                        int'($signed(rsp_ch.entry_key)));
            check_field("entry_payload", int'(want.entry_payload), int'(rsp_ch.entry_payload));
            check_field("below_key", int'($signed(want.below_key)),
                        int'($signed(rsp_ch.below_key)));
            check_field("below_payload", int'(want.below_payload), int'(rsp_ch.below_payload));
            check_field("above_key", int'($signed(want.above_key)),
                        int'($signed(rsp_ch.above_key)));
            check_field("above_payload", int'(want.above_payload), int'(rsp_ch.above_payload));
            check_field("entry_count", int'(want.entry_count), int'(rsp_ch.entry_count));
        end
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_response();
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    task automatic test_directed();
        send_command(OP_SEARCH, 16'sd5, 16'h0000);
        send_command(OP_DELETE, 16'sd5, 16'hFFFF);
        send_command(OP_INSERT, 16'sd0, 16'h0000);
        send_command(OP_INSERT, 16'sd0, 16'hFFFF);
        send_command(OP_SEARCH, 16'sd0, 16'h5555);
        send_command(OP_INSERT, 16'sh8000, 16'h1234);
        send_command(OP_INSERT, 16'sh7FFF, 16'hABCD);
        send_command(OP_SEARCH, 16'sh8000, 16'h0000);
        send_command(OP_SEARCH, 16'sh7FFF, 16'h0000);
        send_command(OP_SEARCH, 16'sd100, 16'h0000);
        send_command(OP_SEARCH, -16'sd1, 16'h0000);
        send_command(OP_NOP, -16'sd1, 16'hFFFF);
        send_command(OP_DELETE, 16'sd0, 16'h0000);
        send_command(OP_SEARCH, 16'sd0, 16'h0000);
        send_command(OP_DELETE, 16'sd7, 16'h0000);
        send_command(OP_DELETE, 16'sh7FFF, 16'h0000);
        send_command(OP_SEARCH, 16'sd100, 16'h0000);
        send_command(OP_SEARCH, 16'sh8001, 16'h0000);
        send_command(OP_DELETE, 16'sh8000, 16'h0000);
        send_command(OP_SEARCH, 16'sd0, 16'h0000);
        send_command(OP_SEARCH, 16'sd1, 16'h0000);
        send_command(OP_DELETE, 16'sd0, 16'h0000);
        send_command(OP_SEARCH, 16'sd0, 16'h0000);
    endtask

    // Fills the table to capacity, pushes inserts past it, probes it, then drains it.
    task automatic test_full_table();
        logic signed [KEY_W-1:0] base;
        int n;
        base = KEY_W'($urandom);
        while (tbl_count < DEPTH)
            send_command(OP_INSERT, pick_key(base), PAY_W'($urandom));
        for (n = 0; n < 5; n++)
            send_command(OP_INSERT, pick_key(base), PAY_W'($urandom));
        for (n = 0; n < 30; n++)
            send_command(OP_SEARCH, pick_key(base), PAY_W'($urandom));
        send_command(OP_NOP, pick_key(base), PAY_W'($urandom));
        send_command(OP_DELETE, pick_key(base), PAY_W'($urandom));
        send_command(OP_INSERT, pick_key(base), PAY_W'($urandom));
        send_command(OP_INSERT, pick_key(base), PAY_W'($urandom));
        while (tbl_count > 0)
            send_command(OP_DELETE, pick_key(base), PAY_W'($urandom));
    endtask

    // Rounds of mixed operations, each steering the fill level toward a random target.
    task automatic test_random_mix(input int n_items);
        int done_items;
        int round_left;
        int target;
        int r;
        op_t op;
        logic signed [KEY_W-1:0] base;
        done_items = 0;
        round_left = 0;
        target     = 0;
        base       = '0;
        while (done_items < n_items)
        begin
            if (round_left == 0)
            begin
                case ($urandom_range(4))
                    0: target = 0;
                    1: target = 4;
                    2: target = 32;
                    3: target = 100;
                    default: target = DEPTH;
                endcase
                round_left = $urandom_range(40, 160);
                base       = KEY_W'($urandom);
            end
            no_idle = (done_items >= 600 && done_items < 900);
            r = $urandom_range(99);
            if (r < 3)
                op = OP_NOP;
            else if (tbl_count < target)
                op = (r < 68) ? OP_INSERT : ((r < 83) ? OP_DELETE : OP_SEARCH);
            else
                op = (r < 18) ? OP_INSERT : ((r < 68) ? OP_DELETE : OP_SEARCH);
            send_command(op, pick_key(base), PAY_W'($urandom));
            if (op != OP_NOP)
                done_items++;
            round_left--;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        error_count = 0;
        no_idle     = 1'b0;
        tbl_count   = 0;
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_NOP;
        cmd_ch.key       <= '0;
        cmd_ch.payload   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_mix(1530);

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
